// ----- hw/rtl/sidrc_pkg.sv -----
// Shared types, widths and codes of the sorted id run coalescer.
// No dependencies; every other file of the block imports this package.
package sidrc_pkg;

  // Id and run widths
  localparam int ID_WIDTH = 32;
  localparam int LEN_W    = ID_WIDTH + 1;
  localparam int CNT_W    = 32;
  localparam int CFG_W    = 64;

  // Shared multiplier and product accumulators
  localparam int MUL_W    = 32;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int ACC_W    = MUL_W + CFG_W + 1;

  // Job queue between front and back
  localparam int Q_DEPTH  = 4;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_CAPACITY = 2'd2;

  // Result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_UNSORTED  = 2'd1;
  localparam status_t ST_OVERFLOW  = 2'd2;
  localparam status_t ST_CAPACITY  = 2'd3;

  // Job kinds carried by the queue
  typedef logic [1:0] kind_t;
  localparam kind_t K_RUN   = 2'd0;  // extent of a finished run
  localparam kind_t K_ERR   = 2'd1;  // error result, no run
  localparam kind_t K_FLUSH = 2'd2;  // batch closed while discarding, no result

  typedef struct packed {
    logic [CFG_W-1:0] record_size;
    logic [CFG_W-1:0] base_byte_offset;
    logic [CNT_W-1:0] run_capacity;
  } cfg_t;

  typedef struct packed {
    kind_t               kind;
    logic                closes;  // final job of the batch
    logic                kept;
    status_t             status;
    logic [CNT_W-1:0]    count;
    logic [ID_WIDTH-1:0] start;
    logic [LEN_W-1:0]    len;
  } job_t;

endpackage

// ----- hw/rtl/sidrc_queue.sv -----
// Short job queue that decouples the front classifier from the back unit.
// Depends on sidrc_pkg for the job type and depth.
module sidrc_queue
  import sidrc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t pop_job,
  output logic full,
  output logic empty
);

  job_t                 slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   fill_r, fill_nxt;

  assign full    = (fill_r == Q_CNT_W'(Q_DEPTH));
  assign empty   = (fill_r == '0);
  assign pop_job = slot_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? Q_PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? Q_PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = Q_CNT_W'(fill_r + 1'b1);
    end else if (pop && !push) begin
      fill_nxt = Q_CNT_W'(fill_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Store the pushed job
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ----- hw/rtl/sidrc_front.sv -----
// Front classifier: takes ids, tracks runs, ordering and discarding,
// and pushes one job per result (or batch close) into the queue. Uses sidrc_pkg.
module sidrc_front
  import sidrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_record_id,
  input  logic        in_batch_last,
  input  cfg_t        cfg,
  input  logic        q_full,
  output logic        q_push,
  output job_t        q_job
);

  logic                active_r, active_nxt;
  logic                disc_r, disc_nxt;
  logic                pend_r, pend_nxt;
  logic [ID_WIDTH-1:0] prev_r, prev_nxt;
  logic [ID_WIDTH-1:0] start_r, start_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [CNT_W-1:0]    runs_r, runs_nxt;

  logic                accept;
  logic [ID_WIDTH-1:0] cur;
  logic [ID_WIDTH:0]   prev_inc;
  logic                consec;
  logic [CNT_W-1:0]    runs_inc;
  logic                rs_zero;

  // Hold the input while a final job waits or the queue is full
  assign in_stall = pend_r || q_full;
  assign accept   = in_valid && !in_stall;

  assign cur      = in_record_id[ID_WIDTH-1:0];
  assign prev_inc = {1'b0, prev_r} + 1'b1;
  assign consec   = ({1'b0, cur} == prev_inc);
  assign runs_inc = (runs_r == '1) ? runs_r : CNT_W'(runs_r + 1'b1);
  assign rs_zero  = (cfg.record_size == '0);

  // Classify the id and build the job
  always_comb begin
    active_nxt = active_r;
    disc_nxt   = disc_r;
    pend_nxt   = pend_r;
    prev_nxt   = prev_r;
    start_nxt  = start_r;
    len_nxt    = len_r;
    runs_nxt   = runs_r;
    q_push     = 1'b0;
    q_job      = '0;

    if (pend_r) begin
      // Close the batch with the last run
      if (!q_full) begin
        q_push       = 1'b1;
        q_job.kind   = K_RUN;
        q_job.closes = 1'b1;
        q_job.kept   = (runs_r < cfg.run_capacity);
        q_job.status = (runs_inc > cfg.run_capacity) ? ST_CAPACITY : ST_OK;
        q_job.count  = runs_inc;
        q_job.start  = start_r;
        q_job.len    = len_r;
        runs_nxt     = runs_inc;
        active_nxt   = 1'b0;
        pend_nxt     = 1'b0;
      end
    end else if (accept) begin
      priority if (!active_r) begin
        // First id opens a run
        active_nxt = 1'b1;
        disc_nxt   = 1'b0;
        runs_nxt   = '0;
        prev_nxt   = cur;
        start_nxt  = cur;
        len_nxt    = LEN_W'(1);
        if (rs_zero) begin
          q_push       = 1'b1;
          q_job.kind   = K_ERR;
          q_job.closes = in_batch_last;
          q_job.status = ST_OVERFLOW;
          active_nxt   = !in_batch_last;
          disc_nxt     = !in_batch_last;
        end else begin
          pend_nxt = in_batch_last;
        end
      end else if (disc_r) begin
        // Drop ids up to the last one
        if (in_batch_last) begin
          q_push       = 1'b1;
          q_job.kind   = K_FLUSH;
          q_job.closes = 1'b1;
          disc_nxt     = 1'b0;
          active_nxt   = 1'b0;
        end
      end else if (cur < prev_r) begin
        q_push       = 1'b1;
        q_job.kind   = K_ERR;
        q_job.closes = in_batch_last;
        q_job.status = ST_UNSORTED;
        active_nxt   = !in_batch_last;
        disc_nxt     = !in_batch_last;
      end else begin
        if (cur != prev_r) begin
          if (consec) begin
            len_nxt = LEN_W'(len_r + 1'b1);
          end else begin
            // Gap closes the current run
            q_push      = 1'b1;
            q_job.kind  = K_RUN;
            q_job.kept  = (runs_r < cfg.run_capacity);
            q_job.start = start_r;
            q_job.len   = len_r;
            runs_nxt    = runs_inc;
            start_nxt   = cur;
            len_nxt     = LEN_W'(1);
          end
          prev_nxt = cur;
        end
        pend_nxt = in_batch_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      disc_r   <= 1'b0;
      pend_r   <= 1'b0;
      prev_r   <= '0;
      start_r  <= '0;
      len_r    <= '0;
      runs_r   <= '0;
    end else begin
      active_r <= active_nxt;
      disc_r   <= disc_nxt;
      pend_r   <= pend_nxt;
      prev_r   <= prev_nxt;
      start_r  <= start_nxt;
      len_r    <= len_nxt;
      runs_r   <= runs_nxt;
    end
  end

endmodule

// ----- hw/rtl/sidrc_back.sv -----
// Back unit: takes jobs from the queue, forms byte offset and length with a
// shared 32x32 multiplier, checks overflow and drives the result register. Uses sidrc_pkg.
module sidrc_back
  import sidrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_empty,
  input  job_t        q_job,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_run_offset,
  output logic [63:0] out_run_length,
  output logic        out_run_present,
  output logic        out_run_kept,
  output logic        out_batch_end,
  output logic [1:0]  out_status,
  output logic [31:0] out_run_count
);

  localparam int LEN_X_W = MUL_W + 1;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_M0   = 3'd1;
  localparam logic [2:0] B_M1   = 3'd2;
  localparam logic [2:0] B_M2   = 3'd3;
  localparam logic [2:0] B_M3   = 3'd4;
  localparam logic [2:0] B_M4   = 3'd5;
  localparam logic [2:0] B_M5   = 3'd6;
  localparam logic [2:0] B_OUT  = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic              drop_r, drop_nxt;
  job_t              job_r;
  logic [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]  off_r;
  logic [ACC_W-1:0]  len_r;

  logic [LEN_X_W-1:0] len_x;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic               ovf, fail, slot_free, load_out;

  logic              out_valid_r;
  logic [63:0]       off_out_r, len_out_r;
  logic              present_r, kept_r, end_r;
  status_t           status_r;
  logic [CNT_W-1:0]  count_r;

  assign len_x = LEN_X_W'(job_r.len);

  // Select multiplier operands by step
  always_comb begin
    mul_a = (state_r == B_M0 || state_r == B_M1) ? MUL_W'(job_r.start) : len_x[MUL_W-1:0];
    mul_b = (state_r == B_M0 || state_r == B_M2) ? cfg.record_size[MUL_W-1:0]
                                                 : cfg.record_size[CFG_W-1:MUL_W];
  end

  assign ovf = (cfg.record_size == '0) || (off_r[ACC_W-1:CFG_W] != '0) ||
               (len_r[ACC_W-1:CFG_W] != '0);
  assign fail      = (job_r.kind == K_ERR) || ovf;
  assign slot_free = !out_valid_r || !out_stall;
  assign load_out  = (state_r == B_OUT) && slot_free;
  assign q_pop     = (state_r == B_IDLE) && !q_empty;

  // Sequence the job
  always_comb begin
    state_nxt = state_r;
    drop_nxt  = drop_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          if (drop_r) begin
            drop_nxt = !q_job.closes;
          end else begin
            unique case (q_job.kind)
              K_RUN:   state_nxt = B_M0;
              K_ERR:   state_nxt = B_OUT;
              default: state_nxt = B_IDLE;
            endcase
          end
        end
      end
      B_M0:    state_nxt = B_M1;
      B_M1:    state_nxt = B_M2;
      B_M2:    state_nxt = B_M3;
      B_M3:    state_nxt = B_M4;
      B_M4:    state_nxt = B_M5;
      B_M5:    state_nxt = B_OUT;
      default: begin
        if (slot_free) begin
          state_nxt = B_IDLE;
          drop_nxt  = fail && !job_r.closes;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      drop_r  <= drop_nxt;
    end
  end

  // Latch the job, multiply and accumulate partial products
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
    end
    prod_r <= mul_a * mul_b;
    unique case (state_r)
      B_M1:    off_r <= ACC_W'(prod_r);
      B_M2:    off_r <= off_r + ACC_W'({prod_r, {MUL_W{1'b0}}});
      B_M3: begin
        off_r <= off_r + ACC_W'(cfg.base_byte_offset);
        len_r <= ACC_W'(prod_r);
      end
      B_M4:    len_r <= len_r + ACC_W'({prod_r, {MUL_W{1'b0}}});
      B_M5: begin
        if (len_x[MUL_W]) begin
          len_r <= len_r + ACC_W'({cfg.record_size, {MUL_W{1'b0}}});
        end
      end
      default: begin
      end
    endcase
  end

  // Drive the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (fail) begin
        off_out_r <= '0;
        len_out_r <= '0;
        present_r <= 1'b0;
        kept_r    <= 1'b0;
        end_r     <= 1'b1;
        status_r  <= (job_r.kind == K_ERR) ? job_r.status : ST_OVERFLOW;
        count_r   <= '0;
      end else begin
        off_out_r <= off_r[CFG_W-1:0];
        len_out_r <= len_r[CFG_W-1:0];
        present_r <= 1'b1;
        kept_r    <= job_r.kept;
        end_r     <= job_r.closes;
        status_r  <= job_r.status;
        count_r   <= job_r.count;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_run_offset  = off_out_r;
  assign out_run_length  = len_out_r;
  assign out_run_present = present_r;
  assign out_run_kept    = kept_r;
  assign out_batch_end   = end_r;
  assign out_status      = status_r;
  assign out_run_count   = count_r;

endmodule

// ----- hw/rtl/sorted_id_run_coalescer_unit.sv -----
// Top level of the sorted id run coalescer: configuration registers,
// front classifier, job queue and back extent unit. Uses sidrc_pkg.
//
//   channel  direction  handshake            beat
//   in_      input      in_valid / in_stall  record_id, batch_last
//   out_     output     out_valid / out_stall run_offset .. run_count
//   cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// The front takes one id per cycle while in_stall is low; an id that ends a
// batch without error is followed by a step spent pushing the closing job.
// A run result steps the back through B_M0..B_M5 and B_OUT (one shared 32x32
// multiplier stepped over four partial products), an error result goes to
// B_OUT; a dropped job is popped in B_IDLE, and no job is popped outside it.
// Synchronous active-low reset clears control state; config resets to 1, 0, 0.
// The front stalls when its four-entry queue is full or a closing job waits.
module sorted_id_run_coalescer_unit
  import sidrc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          in_record_id,
  input  logic                 in_batch_last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [63:0]          out_run_offset,
  output logic [63:0]          out_run_length,
  output logic                 out_run_present,
  output logic                 out_run_kept,
  output logic                 out_batch_end,
  output logic [1:0]           out_status,
  output logic [31:0]          out_run_count,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t cfg_r;
  logic q_push, q_pop, q_full, q_empty;
  job_t push_job, pop_job;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.record_size      <= CFG_W'(1);
      cfg_r.base_byte_offset <= '0;
      cfg_r.run_capacity     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RECORD_SIZE:  cfg_r.record_size      <= cfg_wdata;
        REG_BASE_OFFSET:  cfg_r.base_byte_offset <= cfg_wdata;
        REG_RUN_CAPACITY: cfg_r.run_capacity     <= cfg_wdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sidrc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_record_id  (in_record_id),
    .in_batch_last (in_batch_last),
    .cfg           (cfg_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (push_job)
  );

  sidrc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  sidrc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_empty         (q_empty),
    .q_job           (pop_job),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_run_offset  (out_run_offset),
    .out_run_length  (out_run_length),
    .out_run_present (out_run_present),
    .out_run_kept    (out_run_kept),
    .out_batch_end   (out_batch_end),
    .out_status      (out_status),
    .out_run_count   (out_run_count)
  );

endmodule
